@@ sv/hkv_pkg.sv @@
package hkv_pkg;

	localparam int Buckets = 256;
	localparam int Ways = 4;
	localparam int BktW = $clog2(Buckets);
	localparam int WayW = $clog2(Ways);
	localparam int FillW = $clog2(Ways + 1);
	localparam int AddrW = $clog2(Buckets * Ways);
	localparam int CntW = 11;

	localparam logic [2:0] ST_HIT      = 3'd0;
	localparam logic [2:0] ST_MISS     = 3'd1;
	localparam logic [2:0] ST_UPDATED  = 3'd2;
	localparam logic [2:0] ST_INSERTED = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	// configuration register byte addresses
	localparam logic [2:0] REG_KEY_BYTES = 3'd0;
	localparam logic [2:0] REG_BKT_COUNT = 3'd4;

	// classified item handed from front to back
	typedef struct packed {
		logic              op;
		logic [31:0]       key;
		logic [31:0]       value;
		logic [31:0]       mask;
		logic [BktW-1:0]   bucket;
	} hkv_cmd_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [31:0]       value_out;
		logic [CntW-1:0]   entry_count;
	} hkv_res_t;

endpackage

@@ sv/hkv_front.sv @@
// Hashes the key one byte a cycle, folds the hash to a bucket by restoring
// subtraction (one quotient bit a cycle), and emits a classified command.
module hkv_front import hkv_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            op,
	input  logic [31:0]     key,
	input  logic [31:0]     value,
	input  logic [2:0]      key_bytes,
	input  logic [8:0]      bucket_count,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output hkv_cmd_t        cmd
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_HASH = 4'b0010,
		F_MOD  = 4'b0100,
		F_OUT  = 4'b1000
	} fstate_t;

	fstate_t      state_q;
	logic         op_q;
	logic [31:0]  key_q, value_q, mask_q, h_q;
	logic [2:0]   nb_q, idx_q;
	logic [8:0]   div_q;
	logic [8:0]   rem_q;
	logic [5:0]   bit_q;
	logic [2:0]   nb_eff;
	logic [8:0]   bc_eff;
	logic [31:0]  h_a, h_b, h_c, f_a, f_b, f_c;
	logic [9:0]   rem_sh;

	always_comb begin
		if (key_bytes == 3'd0) nb_eff = 3'd1;
		else if (key_bytes > 3'd4) nb_eff = 3'd4;
		else nb_eff = key_bytes;
		if (bucket_count == 9'd0) bc_eff = 9'd1;
		else if (bucket_count > 9'(Buckets)) bc_eff = 9'(Buckets);
		else bc_eff = bucket_count;
	end

	always_comb begin
		h_a = h_q + {24'd0, key_q[8*idx_q[1:0] +: 8]};
		h_b = h_a + (h_a << 10);
		h_c = h_b ^ (h_b >> 6);
		f_a = h_q + (h_q << 3);
		f_b = f_a ^ (f_a >> 11);
		f_c = f_b + (f_b << 15);
		rem_sh = {rem_q, h_q[31]};
	end

	assign in_ready  = (state_q == F_IDLE);
	assign cmd_valid = (state_q == F_OUT);
	assign cmd.op     = op_q;
	assign cmd.key    = key_q;
	assign cmd.value  = value_q;
	assign cmd.mask   = mask_q;
	assign cmd.bucket = rem_q[BktW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: if (in_valid) state_q <= F_HASH;
				F_HASH: if (idx_q == nb_q) state_q <= F_MOD;
				F_MOD:  if (bit_q == 6'd31) state_q <= F_OUT;
				F_OUT:  if (cmd_ready) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				op_q    <= op;
				key_q   <= key;
				value_q <= value;
				nb_q    <= nb_eff;
				div_q   <= bc_eff;
				idx_q   <= 3'd0;
				h_q     <= 32'd0;
				case (nb_eff)
					3'd1: mask_q <= 32'h0000_00FF;
					3'd2: mask_q <= 32'h0000_FFFF;
					3'd3: mask_q <= 32'h00FF_FFFF;
					default: mask_q <= 32'hFFFF_FFFF;
				endcase
			end
			F_HASH: begin
				if (idx_q == nb_q) begin
					h_q   <= f_c;
					rem_q <= 9'd0;
					bit_q <= 6'd0;
				end else begin
					h_q   <= h_c;
					idx_q <= idx_q + 3'd1;
				end
			end
			F_MOD: begin
				// shift one hash bit into the remainder, subtract if it fits
				h_q   <= h_q << 1;
				bit_q <= bit_q + 6'd1;
				if (rem_sh >= {1'b0, div_q}) rem_q <= 9'(rem_sh - {1'b0, div_q});
				else rem_q <= rem_sh[8:0];
			end
			default: ;
		endcase
	end

endmodule

@@ sv/hkv_back.sv @@
// Reads the bucket fill, scans the bucket one way at a time in the entry
// memories (a read step and a compare step per way), then answers a get or applies a set.
module hkv_back import hkv_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  hkv_cmd_t        cmd,
	output logic            res_valid,
	input  logic            res_ready,
	output hkv_res_t        res
);

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_FILL = 6'b000010,
		B_SCAN = 6'b000100,
		B_CMP  = 6'b001000,
		B_DONE = 6'b010000,
		B_OUT  = 6'b100000
	} bstate_t;

	bstate_t         state_q;
	hkv_cmd_t        cmd_q;
	logic [31:0]     keys_mem [Buckets*Ways];
	logic [31:0]     vals_mem [Buckets*Ways];
	logic [FillW-1:0] fill_mem [Buckets];
	logic [Buckets-1:0] fill_vld_q;
	logic [FillW-1:0] fill_q;
	logic [FillW-1:0] way_q;
	logic [31:0]     rkey_q, rval_q;
	logic [CntW-1:0] total_q;
	logic            found_q;
	logic [2:0]      status_q;
	logic [31:0]     value_out_q;
	logic [AddrW-1:0] addr;
	logic [AddrW-1:0] ins_addr;

	assign addr     = {cmd_q.bucket, way_q[WayW-1:0]};
	assign ins_addr = {cmd_q.bucket, fill_q[WayW-1:0]};
	assign cmd_ready = (state_q == B_IDLE);
	assign res_valid = (state_q == B_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			fill_vld_q <= '0;
			total_q    <= '0;
		end else begin
			case (state_q)
				B_IDLE: if (cmd_valid) state_q <= B_FILL;
				B_FILL: state_q <= B_SCAN;
				B_SCAN: state_q <= (way_q == fill_q) ? B_DONE : B_CMP;
				B_CMP: begin
					if (((rkey_q ^ cmd_q.key) & cmd_q.mask) == 32'd0) state_q <= B_DONE;
					else state_q <= B_SCAN;
				end
				B_DONE: begin
					state_q <= B_OUT;
					if (cmd_q.op == OP_SET && !found_q && fill_q != FillW'(Ways)) begin
						fill_vld_q[cmd_q.bucket] <= 1'b1;
						total_q <= total_q + CntW'(1);
					end
				end
				B_OUT: if (res_ready) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				cmd_q   <= cmd;
				way_q   <= '0;
				found_q <= 1'b0;
			end
			B_FILL: begin
				fill_q <= fill_vld_q[cmd_q.bucket] ? fill_mem[cmd_q.bucket] : '0;
			end
			B_SCAN: begin
				rkey_q <= keys_mem[addr];
				rval_q <= vals_mem[addr];
			end
			B_CMP: begin
				if (((rkey_q ^ cmd_q.key) & cmd_q.mask) == 32'd0) found_q <= 1'b1;
				else way_q <= way_q + FillW'(1);
			end
			B_DONE: begin
				value_out_q <= 32'd0;
				if (cmd_q.op == OP_GET) begin
					status_q <= found_q ? ST_HIT : ST_MISS;
					if (found_q) value_out_q <= rval_q;
				end else if (found_q) begin
					vals_mem[addr] <= cmd_q.value;
					status_q <= ST_UPDATED;
				end else if (fill_q != FillW'(Ways)) begin
					keys_mem[ins_addr] <= cmd_q.key;
					vals_mem[ins_addr] <= cmd_q.value;
					fill_mem[cmd_q.bucket] <= fill_q + FillW'(1);
					status_q <= ST_INSERTED;
				end else begin
					status_q <= ST_FULL;
				end
			end
			default: ;
		endcase
	end

	// count reflects the insert committed in the done step
	assign res = {status_q, value_out_q, total_q};

endmodule

@@ sv/hashed_key_value_table_top.sv @@
// Flow per item: the front hashes the key (one step per key byte, then a final
// mix) and runs a 32-step remainder before handing off; the back pops the queue,
// reads the fill, scans the ways, then answers or updates; then the output register.
// The front takes no new item until it has handed off the last; the back works on
// earlier items meanwhile and overlaps through a two-entry queue.
// Reset: arst_n clears control state, bucket fill valid bits and the entry
// count at once; registers return to key_bytes 4, bucket_count 256.
module hashed_key_value_table_top import hkv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // op[0], key[32:1], value[64:33], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // status[2:0], value_out[34:3], entry_count[45:35], pad
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [2:0]  key_bytes_q;
	logic [8:0]  bucket_count_q;
	logic        f_valid, f_ready, q_valid, q_ready, b_res_valid, b_res_ready;
	hkv_cmd_t    f_cmd, q_cmd;
	hkv_cmd_t    fifo_q [2];
	logic [1:0]  cnt_q;
	logic        wr_q, rd_q;
	hkv_res_t    b_res;
	hkv_res_t    out_q;
	logic        out_vld_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bytes_q    <= 3'd4;
			bucket_count_q <= 9'd256;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				REG_KEY_BYTES: key_bytes_q <= pwdata[2:0];
				REG_BKT_COUNT: bucket_count_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			REG_KEY_BYTES: prdata = {29'd0, key_bytes_q};
			REG_BKT_COUNT: prdata = {23'd0, bucket_count_q};
			default: prdata = 32'd0;
		endcase
	end

	hkv_front u_front (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.op(s_tdata[0]), .key(s_tdata[32:1]), .value(s_tdata[64:33]),
		.key_bytes(key_bytes_q), .bucket_count(bucket_count_q),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	// two-entry command queue
	assign f_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd   = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (f_valid && f_ready) wr_q <= ~wr_q;
			if (q_valid && q_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(f_valid && f_ready) - 2'(q_valid && q_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (f_valid && f_ready) fifo_q[wr_q] <= f_cmd;
	end

	hkv_back u_back (
		.clk, .arst_n,
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.res_valid(b_res_valid), .res_ready(b_res_ready), .res(b_res)
	);

	// output register
	assign b_res_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (b_res_ready) begin
			out_vld_q <= b_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (b_res_ready && b_res_valid) out_q <= b_res;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'd0, out_q.entry_count, out_q.value_out, out_q.status};

endmodule

@@ verif/hkv_checker.sv @@
`timescale 1ns / 1ps
module hkv_checker import hkv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,  // op[0], key[32:1], value[64:33], zero pad
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,  // status[2:0], value_out[34:3], entry_count[45:35], pad
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending
);

	logic [2:0]  key_bytes_q;
	logic [8:0]  bucket_count_q;
	logic [2:0]  fill_q [Buckets];
	logic [31:0] keys_q [Buckets*Ways];
	logic [31:0] vals_q [Buckets*Ways];
	logic [31:0] total_q;
	hkv_res_t    expected_q[$];

	function automatic logic [31:0] oaat(input logic [31:0] key, input int nb);
		logic [31:0] h;
		h = 0;
		for (int i = 0; i < nb; i++) begin
			h += (key >> (8*i)) & 32'hFF;
			h += h << 10;
			h ^= h >> 6;
		end
		h += h << 3;
		h ^= h >> 11;
		h += h << 15;
		return h;
	endfunction

	task automatic lookup_and_update(input logic [71:0] d);
		int nb, bc, b, fill, hit_way;
		logic [31:0] mask, key, val;
		hkv_res_t r;
		key = d[32:1];
		val = d[64:33];
		nb = (key_bytes_q < 1) ? 1 : (key_bytes_q > 4) ? 4 : key_bytes_q;
		bc = (bucket_count_q < 1) ? 1 : (bucket_count_q > Buckets) ? Buckets : bucket_count_q;
		mask = (nb >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8*nb)) - 1);
		b = oaat(key, nb) % bc;
		fill = (fill_q[b] > Ways) ? Ways : fill_q[b];
		hit_way = -1;
		for (int i = 0; i < fill; i++)
			if (hit_way < 0 && ((keys_q[b*Ways+i] ^ key) & mask) == 0) hit_way = i;
		r.value_out = 0;
		if (d[0] == OP_GET) begin
			if (hit_way >= 0) begin
				r.status = ST_HIT;
				r.value_out = vals_q[b*Ways+hit_way];
			end else r.status = ST_MISS;
		end else if (hit_way >= 0) begin
			vals_q[b*Ways+hit_way] = val;
			r.status = ST_UPDATED;
		end else if (fill < Ways) begin
			keys_q[b*Ways+fill] = key;
			vals_q[b*Ways+fill] = val;
			fill_q[b] = fill + 1;
			total_q++;
			r.status = ST_INSERTED;
		end else r.status = ST_FULL;
		r.entry_count = total_q[CntW-1:0];
		expected_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		hkv_res_t exp_r;
		if (!arst_n) begin
			key_bytes_q = 4;
			bucket_count_q = 256;
			for (int i = 0; i < Buckets; i++) fill_q[i] = 0;
			total_q = 0;
			expected_q.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr == REG_KEY_BYTES) key_bytes_q = pwdata[2:0];
				else if (paddr == REG_BKT_COUNT) bucket_count_q = pwdata[8:0];
			end
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result item %h", m_tdata);
					fail_count++;
				end else begin
					exp_r = expected_q.pop_front();
					if (m_tdata[2:0] !== exp_r.status) begin
						$error("status exp %0d got %0d", exp_r.status, m_tdata[2:0]);
						fail_count++;
					end
					if (m_tdata[34:3] !== exp_r.value_out) begin
						$error("value_out exp %h got %h", exp_r.value_out, m_tdata[34:3]);
						fail_count++;
					end
					if (m_tdata[45:35] !== exp_r.entry_count) begin
						$error("entry_count exp %0d got %0d", exp_r.entry_count,
							m_tdata[45:35]);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) lookup_and_update(s_tdata);
		end
		pending = expected_q.size();
	end

endmodule

@@ verif/tb_hashed_key_value_table_top.sv @@
`timescale 1ns / 1ps
module tb_hashed_key_value_table_top import hkv_pkg::*;;

	localparam int WatchdogLimit = 20000;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [71:0] s_tdata;  // op[0], key[32:1], value[64:33], zero pad
	logic [47:0] m_tdata;  // status[2:0], value_out[34:3], entry_count[45:35], pad
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	int fail_count, pending;
	int send_idle_pct, recv_idle_pct, quiet_cycles;
	logic [31:0] key_pool[$];

	hashed_key_value_table_top i_dut (.*);
	hkv_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver stall
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("** hashed_key_value_table_top: FAILED **");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic send_item(input logic op, input logic [31:0] key, input logic [31:0] val);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		s_tdata <= {7'd0, val, key, op};
		s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		s_tvalid <= 0;
	endtask

	task automatic drain_queue();
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// most keys reused so that hits, updates and full buckets come up
	task automatic random_items(input int n);
		logic [31:0] k;
		for (int i = 0; i < n; i++) begin
			if (key_pool.size() == 0 || $urandom_range(3) == 0) begin
				k = $urandom;
				key_pool.push_back(k);
			end else k = key_pool[$urandom_range(key_pool.size() - 1)]
				^ ($urandom_range(3) == 0 ? {8'($urandom_range(255)), 24'd0} : 32'd0);
			send_item($urandom_range(1), k, $urandom);
		end
	endtask

	initial begin
		s_tvalid = 0; s_tdata = 0; m_tready = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		send_idle_pct = 16; recv_idle_pct = 86; quiet_cycles = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// directed: extremes, miss, insert, update, hit
		send_item(OP_GET, 32'h0, 32'h0);
		send_item(OP_SET, 32'h0, 32'h8000_0000);
		send_item(OP_GET, 32'h0, 32'h0);
		send_item(OP_SET, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_item(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_GET, 32'hFFFF_FFFF, 32'h0);
		drain_queue();
		// one bucket: fill it, then overflow, then a byte-masked compare
		reg_write(REG_BKT_COUNT, 32'd1);
		reg_write(REG_KEY_BYTES, 32'd1);
		for (int i = 1; i <= 6; i++) send_item(OP_SET, 32'hAB00 + i, i);
		send_item(OP_GET, 32'hFF03, 0);
		drain_queue();
		// out-of-range settings clamp
		reg_write(REG_KEY_BYTES, 32'd0);
		reg_write(REG_BKT_COUNT, 32'd0);
		send_item(OP_GET, 32'h1234_5605, 0);
		send_item(OP_SET, 32'h77, 32'h5);
		drain_queue();
		reg_write(REG_KEY_BYTES, 32'd7);
		reg_write(REG_BKT_COUNT, 32'h1FF);
		send_item(OP_SET, 32'h77, 32'h6);
		send_item(OP_GET, 32'h77, 0);
		drain_queue();

		reg_write(REG_KEY_BYTES, 32'd2);
		reg_write(REG_BKT_COUNT, 32'd3);
		random_items(120);
		drain_queue();
		send_idle_pct = 86; recv_idle_pct = 16;
		reg_write(REG_KEY_BYTES, 32'd3);
		reg_write(REG_BKT_COUNT, 32'd256);
		random_items(250);
		drain_queue();
		send_idle_pct = 0; recv_idle_pct = 0;
		reg_write(REG_KEY_BYTES, 32'd4);
		reg_write(REG_BKT_COUNT, 32'd17);
		random_items(330);
		drain_queue();

		if (fail_count == 0) $display("** hashed_key_value_table_top: PASSED **");
		else $display("** hashed_key_value_table_top: FAILED **");
		$finish;
	end

endmodule
